// ----- rtl/core/cst_pkg.sv -----
package cst_pkg;

  // Default sizes
  localparam int KW_ENTRIES_DEF = 16;
  localparam int KW_LEN_DEF     = 32;
  localparam int WORD_LEN_DEF   = 32;

  // Input opcodes
  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_STR   = 2'd1;
  localparam logic [1:0] KIND_IDENT = 2'd2;

  localparam logic [9:0]  TOK_END = 10'd0;
  localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_STR_CODE   = 2'd0;
  localparam logic [1:0] CFG_NUM_CODE   = 2'd1;
  localparam logic [1:0] CFG_IDENT_CODE = 2'd2;
  localparam logic [1:0] CFG_KW_COUNT   = 2'd3;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] SPECIALS [10] = '{8'h2C, 8'h7B, 8'h7D, 8'h7C, 8'h3A,
                                           8'h28, 8'h29, 8'h40, 8'h23, 8'h3B};

  typedef enum logic [2:0] {
    M_IDLE, M_STRING, M_ZERO, M_DEC, M_HEX, M_WORD
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_REP, ST_FIN, ST_TAIL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SRC_REP, SRC_FIN, SRC_TAIL
  } out_src_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_byte;
    logic [3:0] entry_index;
    logic [4:0] entry_pos;
    logic [9:0] entry_token;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [9:0]  token_code;
    logic [30:0] token_value;
    logic [7:0]  text_char;
    logic        too_long;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic     accept;
    logic     eval;
    logic     emit;
    out_src_t src;
    logic     last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic fresh;
    logic rep_left;
    logic has_fin;
    logic has_tail;
  } dp_status_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_special(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (SPECIALS[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(c)) r = {1'b1, 4'(c - CH_ZERO)};
    else if ((c >= 8'h61) && (c <= 8'h66)) r = {1'b1, 4'(c - 8'h57)};
    else if ((c >= 8'h41) && (c <= 8'h46)) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

// ----- rtl/core/char_stream_tokenizer.sv -----
// Byte-stream tokenizer with a loadable keyword table.
// Input channel (in_valid/in_ready/in_data): one transaction per text byte,
// end-of-input marker or keyword table character load.
// Output channel (out_valid/out_ready/out_data): tokens, string content bytes
// and identifier bytes; "last" marks the final result of an input transaction.
// Configuration: cfg_we/cfg_index/cfg_data write the token codes and the
// keyword count; write only while no transaction is in progress.
// Sequencing: an input transaction passes through accept, evaluate, then
// one step each for identifier replay, finished token and trailing token,
// before the next one can be accepted; each replayed identifier byte waits
// for a fresh registered read of the word buffer. Keyword lookups match all
// entries in parallel against one registered table read per byte.
// Reset clears the scanner to idle, counters and config to zero; keyword
// table contents are undefined until loaded.
// A stalled receiver holds a result in the output register; sequencing waits,
// and no input is taken until the last result of a transaction is registered.
module char_stream_tokenizer #(
  parameter int KEYWORD_ENTRIES = cst_pkg::KW_ENTRIES_DEF,
  parameter int KEYWORD_LEN     = cst_pkg::KW_LEN_DEF,
  parameter int WORD_LEN        = cst_pkg::WORD_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);
  import cst_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  cst_datapath #(
    .KEYWORD_ENTRIES(KEYWORD_ENTRIES),
    .KEYWORD_LEN    (KEYWORD_LEN),
    .WORD_LEN       (WORD_LEN)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

// ----- rtl/core/cst_kwtable.sv -----
module cst_kwtable #(
  parameter int KEYWORD_ENTRIES = cst_pkg::KW_ENTRIES_DEF,
  parameter int KEYWORD_LEN     = cst_pkg::KW_LEN_DEF,
  localparam int KA = $clog2(KEYWORD_LEN),
  localparam int EW = (KEYWORD_ENTRIES > 1) ? $clog2(KEYWORD_ENTRIES) : 1
) (
  input  logic                              clk,
  input  logic                              wr,
  input  logic [3:0]                        wr_entry,
  input  logic [4:0]                        wr_pos,
  input  logic [7:0]                        wr_char,
  input  logic [9:0]                        wr_token,
  input  logic [KA-1:0]                     rd_pos,
  input  logic [EW-1:0]                     code_addr,
  output logic [KEYWORD_ENTRIES-1:0][7:0]   kw_row,
  output logic [9:0]                        code_rd
);
  import cst_pkg::*;

  logic [6:0] entry_ext, pos_ext;
  logic       in_range;
  logic [9:0] codes [KEYWORD_ENTRIES];

  assign entry_ext = 7'(wr_entry);
  assign pos_ext   = 7'(wr_pos);
  assign in_range  = (entry_ext < 7'(KEYWORD_ENTRIES)) && (pos_ext < 7'(KEYWORD_LEN));

  // One character memory per entry, all read at the same position
  for (genvar g = 0; g < KEYWORD_ENTRIES; g++) begin : g_entry
    logic [7:0] chars [KEYWORD_LEN];
    always_ff @(posedge clk) begin
      if (wr && in_range && (entry_ext == 7'(g))) begin
        chars[pos_ext[KA-1:0]] <= wr_char;
      end
      kw_row[g] <= chars[rd_pos];
    end
  end

  // Token codes, read at the winning entry
  always_ff @(posedge clk) begin
    if (wr && in_range) begin
      codes[entry_ext[EW-1:0]] <= wr_token;
    end
    code_rd <= codes[code_addr];
  end

endmodule

// ----- rtl/core/cst_datapath.sv -----
module cst_datapath #(
  parameter int KEYWORD_ENTRIES = cst_pkg::KW_ENTRIES_DEF,
  parameter int KEYWORD_LEN     = cst_pkg::KW_LEN_DEF,
  parameter int WORD_LEN        = cst_pkg::WORD_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cst_pkg::ctrl_cmd_t    cmd,
  output cst_pkg::dp_status_t   status,
  input  cst_pkg::in_item_t     in_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output cst_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [9:0]            cfg_data
);
  import cst_pkg::*;

  localparam int WLW = $clog2(WORD_LEN + 2);
  localparam int KA  = $clog2(KEYWORD_LEN);
  localparam int EW  = (KEYWORD_ENTRIES > 1) ? $clog2(KEYWORD_ENTRIES) : 1;
  localparam logic [KEYWORD_ENTRIES-1:0] ALL_MATCH = '1;

  // Configuration
  logic [9:0] str_code, num_code, ident_code;
  logic [4:0] kw_count;

  // Scanner state
  scan_mode_t           mode, mode_next;
  logic [30:0]          accum, accum_next;
  logic [3:0]           dcnt, dcnt_next;
  logic [WLW-1:0]       wlen, wlen_next;
  logic [KEYWORD_ENTRIES-1:0] mvec, mvec_next;
  logic [30:0]          sctr, sctr_next, ictr, ictr_next;

  // Latched item
  logic [1:0] op_q;
  logic [7:0] ch_q;

  // Plan of the current item
  logic        has_rep, has_fin, has_tail, fin_kw, rep_tl, fin_tl;
  logic [1:0]  fin_kind;
  logic [9:0]  fin_code, tail_code;
  logic [30:0] fin_val, rep_val;
  logic [7:0]  fin_char;
  logic [WLW-1:0] rep_len, rcnt;
  logic [EW-1:0]  hit_q;
  logic        fresh;
  logic        p_rep, p_fin, p_tail, p_kw, p_tl, p_rtl;
  logic [1:0]  p_kind;
  logic [9:0]  p_code, p_tcode;
  logic [30:0] p_val, p_rval;
  logic [7:0]  p_char;
  logic [WLW-1:0] p_rlen;

  // Step flags and helpers
  logic        fin_num, fin_str, fin_word, go_idle, dig_go, dig_zero, dig_hex;
  logic        wadd, wadd_zero, over, hit;
  logic [3:0]  dig_val;
  logic [4:0]  hx;
  logic [30:0] dsrc;
  logic [34:0] prod;
  logic [WLW-1:0] bl, len;
  logic [6:0]  bl_ext, len_ext, wlen_ext;
  logic [KEYWORD_ENTRIES-1:0] mism, cand, msrc;
  logic [EW-1:0] hit_idx;
  logic        wb_we;
  logic [WLW-1:0] wb_addr;

  // Word buffer and keyword table
  logic [7:0] wbuf [WORD_LEN];
  logic [7:0] wb_rd;
  logic [KEYWORD_ENTRIES-1:0][7:0] kw_row;
  logic [9:0] code_rd;
  logic [EW-1:0] code_addr;

  assign wlen_ext  = 7'(wlen);
  assign code_addr = cmd.eval ? hit_idx : hit_q;

  cst_kwtable #(
    .KEYWORD_ENTRIES(KEYWORD_ENTRIES),
    .KEYWORD_LEN    (KEYWORD_LEN)
  ) u_kwtable (
    .clk      (clk),
    .wr       (cmd.accept && (in_data.opcode == OP_LOAD)),
    .wr_entry (in_data.entry_index),
    .wr_pos   (in_data.entry_pos),
    .wr_char  (in_data.char_byte),
    .wr_token (in_data.entry_token),
    .rd_pos   (wlen_ext[KA-1:0]),
    .code_addr(code_addr),
    .kw_row   (kw_row),
    .code_rd  (code_rd)
  );

  // Keyword candidates for a finishing word
  always_comb begin
    over    = wlen_ext > 7'(WORD_LEN);
    len     = over ? WLW'(WORD_LEN) : wlen;
    len_ext = 7'(len);
    hit_idx = '0;
    for (int i = KEYWORD_ENTRIES - 1; i >= 0; i--) begin
      cand[i] = mvec[i] && (7'(i) < 7'(kw_count)) &&
                ((len_ext >= 7'(KEYWORD_LEN)) || (kw_row[i] == 8'd0));
      if (cand[i]) hit_idx = EW'(i);
    end
    hit = (|cand) && !over;
  end

  // Evaluation of one latched item
  always_comb begin
    mode_next  = mode;
    accum_next = accum;
    dcnt_next  = dcnt;
    wlen_next  = wlen;
    mvec_next  = mvec;
    sctr_next  = sctr;
    ictr_next  = ictr;
    p_rep = 1'b0; p_fin = 1'b0; p_tail = 1'b0; p_kw = 1'b0;
    p_tl = 1'b0; p_rtl = 1'b0; p_kind = KIND_TOKEN;
    p_code = '0; p_tcode = TOK_END; p_val = '0; p_rval = '0; p_char = '0;
    p_rlen = '0;
    fin_num = 1'b0; fin_str = 1'b0; fin_word = 1'b0; go_idle = 1'b0;
    dig_go = 1'b0; dig_zero = 1'b0; dig_hex = 1'b0; dig_val = '0;
    wadd = 1'b0; wadd_zero = 1'b0;
    hx = hex_digit(ch_q);

    // Decide what this item does
    if (op_q == OP_TEXT) begin
      unique case (mode)
        M_STRING: begin
          if (ch_q == CH_QUOTE) begin
            fin_str = 1'b1;
          end else begin
            p_fin = 1'b1; p_kind = KIND_STR; p_code = str_code;
            p_val = sctr; p_char = ch_q;
          end
        end
        M_ZERO: begin
          if ((ch_q == CH_LOW_X) || (ch_q == CH_UP_X)) begin
            mode_next = M_HEX;
          end else if (is_digit(ch_q)) begin
            dig_go = 1'b1; dig_val = hx[3:0]; mode_next = M_DEC;
          end else begin
            fin_num = 1'b1; go_idle = 1'b1;
          end
        end
        M_DEC: begin
          if (is_digit(ch_q)) begin
            dig_go = 1'b1; dig_val = hx[3:0];
          end else begin
            fin_num = 1'b1; go_idle = 1'b1;
          end
        end
        M_HEX: begin
          if (hx[4]) begin
            dig_go = 1'b1; dig_hex = 1'b1; dig_val = hx[3:0];
          end else begin
            fin_num = 1'b1; go_idle = 1'b1;
          end
        end
        M_WORD: begin
          if (!is_ws(ch_q) && !is_special(ch_q)) begin
            wadd = 1'b1;
          end else begin
            fin_word = 1'b1; go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
    end else if (op_q == OP_END) begin
      unique case (mode)
        M_STRING:             fin_str = 1'b1;
        M_ZERO, M_DEC, M_HEX: fin_num = 1'b1;
        M_WORD:               fin_word = 1'b1;
        default:              ;
      endcase
      p_tail = 1'b1; p_tcode = TOK_END;
    end

    // Finish the pending token
    if (fin_num) begin
      p_fin = 1'b1; p_code = num_code; p_val = accum; p_tl = dcnt > 4'd9;
    end
    if (fin_str) begin
      p_fin = 1'b1; p_code = str_code; p_val = sctr;
      sctr_next = sctr + 31'd1;
    end
    if (fin_word) begin
      p_fin = 1'b1;
      if (hit) begin
        p_kw = 1'b1;
      end else begin
        p_rep = 1'b1; p_rlen = len; p_rval = ictr; p_rtl = over;
        p_code = ident_code; p_val = ictr; p_tl = over;
        ictr_next = ictr + 31'd1;
      end
      wlen_next = '0;
      mvec_next = ALL_MATCH;
    end
    if (fin_num || fin_str || fin_word || (op_q == OP_END)) begin
      mode_next = M_IDLE;
    end

    // Start of a token at the current byte
    if (go_idle && !is_ws(ch_q)) begin
      if (is_special(ch_q)) begin
        p_tail = 1'b1; p_tcode = {2'b00, ch_q};
      end else begin
        accum_next = '0;
        dcnt_next  = '0;
        if (ch_q == CH_QUOTE) begin
          mode_next = M_STRING;
        end else if (ch_q == CH_ZERO) begin
          mode_next = M_ZERO;
        end else if (is_digit(ch_q)) begin
          dig_go = 1'b1; dig_zero = 1'b1; dig_val = hx[3:0]; mode_next = M_DEC;
        end else begin
          wadd = 1'b1; wadd_zero = 1'b1; mode_next = M_WORD;
        end
      end
    end

    // Digit accumulation with saturation
    dsrc = dig_zero ? '0 : accum;
    prod = dig_hex ? ({4'd0, dsrc} << 4) + 35'(dig_val)
                   : ({4'd0, dsrc} << 3) + ({4'd0, dsrc} << 1) + 35'(dig_val);
    if (dig_go) begin
      accum_next = (prod > 35'(VAL_MAX)) ? VAL_MAX : prod[30:0];
      dcnt_next  = dig_zero ? 4'd1 : ((dcnt < 4'd15) ? dcnt + 4'd1 : dcnt);
    end

    // Word byte: store and narrow the keyword candidates
    bl      = wadd_zero ? '0 : wlen;
    bl_ext  = 7'(bl);
    msrc    = wadd_zero ? ALL_MATCH : mvec;
    wb_we   = 1'b0;
    wb_addr = bl;
    for (int i = 0; i < KEYWORD_ENTRIES; i++) begin
      mism[i] = (bl_ext >= 7'(KEYWORD_LEN)) || (kw_row[i] != ch_q);
    end
    if (wadd) begin
      if (bl_ext >= 7'(WORD_LEN)) begin
        wlen_next = WLW'(WORD_LEN + 1);
        mvec_next = msrc;
      end else begin
        wb_we     = 1'b1;
        mvec_next = msrc & ~mism;
        wlen_next = bl + WLW'(1);
      end
    end
  end

  // Word buffer
  always_ff @(posedge clk) begin
    if (cmd.eval && wb_we) begin
      wbuf[wb_addr[$clog2(WORD_LEN)-1:0]] <= ch_q;
    end
    wb_rd <= wbuf[rcnt[$clog2(WORD_LEN)-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      str_code   <= '0;
      num_code   <= '0;
      ident_code <= '0;
      kw_count   <= '0;
      mode       <= M_IDLE;
      accum      <= '0;
      dcnt       <= '0;
      wlen       <= '0;
      mvec       <= ALL_MATCH;
      sctr       <= '0;
      ictr       <= '0;
      has_rep    <= 1'b0;
      has_fin    <= 1'b0;
      has_tail   <= 1'b0;
      rcnt       <= '0;
      fresh      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STR_CODE:   str_code   <= cfg_data;
          CFG_NUM_CODE:   num_code   <= cfg_data;
          CFG_IDENT_CODE: ident_code <= cfg_data;
          CFG_KW_COUNT:   kw_count   <= cfg_data[4:0];
        endcase
      end
      if (cmd.eval) begin
        mode     <= mode_next;
        accum    <= accum_next;
        dcnt     <= dcnt_next;
        wlen     <= wlen_next;
        mvec     <= mvec_next;
        sctr     <= sctr_next;
        ictr     <= ictr_next;
        has_rep  <= p_rep;
        has_fin  <= p_fin;
        has_tail <= p_tail;
        rcnt     <= '0;
      end else if (cmd.emit && (cmd.src == SRC_REP)) begin
        rcnt <= rcnt + WLW'(1);
      end
      fresh <= !(cmd.eval || (cmd.emit && (cmd.src == SRC_REP)));
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= in_data.opcode;
      ch_q <= in_data.char_byte;
    end
    if (cmd.eval) begin
      fin_kw    <= p_kw;
      fin_kind  <= p_kind;
      fin_code  <= p_code;
      fin_val   <= p_val;
      fin_char  <= p_char;
      fin_tl    <= p_tl;
      tail_code <= p_tcode;
      rep_len   <= p_rlen;
      rep_val   <= p_rval;
      rep_tl    <= p_rtl;
      hit_q     <= hit_idx;
    end
    if (cmd.emit) begin
      unique case (cmd.src)
        SRC_REP: out_data <= '{result_kind: KIND_IDENT, token_code: ident_code,
                               token_value: rep_val, text_char: wb_rd,
                               too_long: rep_tl, last: cmd.last};
        SRC_FIN: out_data <= '{result_kind: fin_kind,
                               token_code: fin_kw ? code_rd : fin_code,
                               token_value: fin_val, text_char: fin_char,
                               too_long: fin_tl, last: cmd.last};
        default: out_data <= '{result_kind: KIND_TOKEN, token_code: tail_code,
                               token_value: '0, text_char: '0,
                               too_long: 1'b0, last: cmd.last};
      endcase
    end
  end

  assign status = '{slot_free: !out_valid || out_ready,
                    fresh:     fresh,
                    rep_left:  has_rep && (rcnt != rep_len),
                    has_fin:   has_fin,
                    has_tail:  has_tail};

endmodule

// ----- rtl/core/cst_ctrl.sv -----
module cst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cst_pkg::dp_status_t  status,
  output cst_pkg::ctrl_cmd_t   cmd
);
  import cst_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing: evaluate, replay identifier bytes, finished token, trailing token
  always_comb begin
    state_next = state;
    cmd        = '{accept: 1'b0, eval: 1'b0, emit: 1'b0, src: SRC_TAIL, last: 1'b0};
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_REP;
      end
      ST_REP: begin
        cmd.src = SRC_REP;
        if (!status.rep_left) begin
          state_next = ST_FIN;
        end else if (status.fresh && status.slot_free) begin
          cmd.emit = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.src  = SRC_FIN;
        cmd.last = !status.has_tail;
        if (!status.has_fin) begin
          state_next = ST_TAIL;
        end else if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd.src  = SRC_TAIL;
        cmd.last = 1'b1;
        if (!status.has_tail) begin
          state_next = ST_IDLE;
        end else if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.slot_free) else $error("emit into an occupied output register");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.eval) else $error("accepted transaction not evaluated");

  a_rep_fresh: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.src == SRC_REP)) |-> (status.fresh && !cmd.last))
    else $error("identifier byte sent from stale buffer read");

endmodule
